// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// No dependencies; every other file but fbpa_ram imports this package.
`default_nettype none
package fbpa_pkg;

    // Input action codes
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_REINIT = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_TOO_BIG  = 2'd1;
    localparam logic [1:0] STAT_EXHAUST  = 2'd2;
    localparam logic [1:0] STAT_BAD_FREE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BLOCK_COUNT   = 1'b0;
    localparam logic CFG_PAYLOAD_BYTES = 1'b1;

    localparam int CFG_DW   = 13;
    localparam int BSIZE_W  = 14;
    localparam int OFFS_W   = 23;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PW     = 1;

    // Command kinds after classification
    localparam logic [2:0] K_NOP      = 3'd0;
    localparam logic [2:0] K_TOO_BIG  = 3'd1;
    localparam logic [2:0] K_ALLOC    = 3'd2;
    localparam logic [2:0] K_FREE     = 3'd3;
    localparam logic [2:0] K_BAD_FREE = 3'd4;
    localparam logic [2:0] K_REINIT   = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] request_bytes;
        logic [9:0]  free_index;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic [9:0]        block_index;
        logic [OFFS_W-1:0] byte_offset;
        logic [1:0]        status;
    } t_result;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] free_index;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/fbpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/fbpa_front.sv =====
// Front stage: takes input items, classifies them and stages one command.
// Depends on fbpa_pkg.
`default_nettype none
module fbpa_front
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_in_item           i_item,
    input  wire logic [10:0]        i_block_count,
    input  wire logic [BSIZE_W-1:0] i_bsize,
    input  wire logic               i_q_full,
    output      logic               o_busy,
    output      logic               o_push,
    output      t_cmd               o_cmd
);
    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic too_big;
    logic bad_free;

    assign o_busy = r_valid & i_q_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_valid & ~i_q_full;
    assign o_cmd  = r_cmd;

    assign too_big  = ({1'b0, i_item.request_bytes} + 17'd4) > 17'(i_bsize);
    assign bad_free = ({1'b0, i_item.free_index} >= i_block_count)
                   || (32'(i_item.free_index) >= MAX_BLOCKS);

    always_comb begin
        n_cmd.free_index = i_item.free_index;
        unique case (i_item.action)
            ACT_ALLOC:  n_cmd.kind = too_big ? K_TOO_BIG : K_ALLOC;
            ACT_FREE:   n_cmd.kind = bad_free ? K_BAD_FREE : K_FREE;
            ACT_REINIT: n_cmd.kind = K_REINIT;
            default:    n_cmd.kind = K_NOP;
        endcase
        n_valid = accept | (r_valid & i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fbpa_queue.sv =====
// Two-entry command queue between the front and back stages.
// Depends on fbpa_pkg.
`default_nettype none
module fbpa_queue
    import fbpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output      logic o_valid,
    output      logic o_full,
    output      t_cmd o_cmd
);
    t_cmd              r_ent [Q_DEPTH];
    logic [Q_PW-1:0]   r_wp;
    logic [Q_PW-1:0]   r_rp;
    logic [Q_PW:0]     r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (Q_PW+1)'(Q_DEPTH);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fbpa_back.sv =====
// Back stage: runs commands against the free list and link memory, forms results.
// Depends on fbpa_pkg and fbpa_ram.
`default_nettype none
module fbpa_back
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int LINK_BYTES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_cmd               i_cmd,
    input  wire logic [10:0]        i_block_count,
    input  wire logic [BSIZE_W-1:0] i_bsize,
    output      logic               o_pop,
    output      logic               o_done,
    output      t_result            o_result
);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int LW    = IDX_W + 1;
    localparam int CW    = (LW > 11) ? LW : 11;
    localparam int PW    = IDX_W + BSIZE_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LINK = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [LW-1:0]    r_head;
    logic [LW-1:0]    n_head;
    logic [LW-1:0]    r_fresh;
    logic [LW-1:0]    n_fresh;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             n_done;
    t_result          n_result;
    logic             ram_we;
    logic [LW-1:0]    ram_rdata;
    logic             fresh_ok;
    logic [PW:0]      offs_sum;

    assign fresh_ok = (CW'(r_fresh) < CW'(i_block_count)) && (32'(r_fresh) < MAX_BLOCKS);
    assign offs_sum = (PW+1)'(r_idx * i_bsize) + (PW+1)'(LINK_BYTES);

    fbpa_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IDX_W'(i_cmd.free_index)),
        .i_wdata (r_head),
        .i_raddr (r_head[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fresh  = r_fresh;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_result = '0;
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_ALLOC: begin
                            if (r_head < NULL_LINK) begin
                                // link of the head comes back next cycle
                                n_idx   = r_head[IDX_W-1:0];
                                n_state = S_LINK;
                            end else if (fresh_ok) begin
                                n_idx   = r_fresh[IDX_W-1:0];
                                n_fresh = r_fresh + 1'b1;
                                n_state = S_MUL;
                            end else begin
                                n_done          = 1'b1;
                                n_result.status = STAT_EXHAUST;
                            end
                        end
                        K_TOO_BIG: begin
                            n_done          = 1'b1;
                            n_result.status = STAT_TOO_BIG;
                        end
                        K_FREE: begin
                            ram_we           = 1'b1;
                            n_head           = LW'(i_cmd.free_index);
                            n_done           = 1'b1;
                            n_result.granted = 1'b1;
                        end
                        K_BAD_FREE: begin
                            n_done          = 1'b1;
                            n_result.status = STAT_BAD_FREE;
                        end
                        K_REINIT: begin
                            n_head           = NULL_LINK;
                            n_fresh          = '0;
                            n_done           = 1'b1;
                            n_result.granted = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_LINK: begin
                n_head  = (ram_rdata > NULL_LINK) ? NULL_LINK : ram_rdata;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_done               = 1'b1;
                n_result.granted     = 1'b1;
                n_result.block_index = 10'(r_idx);
                n_result.byte_offset = OFFS_W'(offs_sum);
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_LINK;
            r_fresh <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fresh <= n_fresh;
            o_done  <= n_done;
        end
        r_idx    <= n_idx;
        o_result <= n_result;
    end
endmodule
`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed block pool allocator: configuration registers,
// block size, and the front, queue and back stages. Depends on fbpa_pkg,
// fbpa_front, fbpa_queue and fbpa_back.
// An item is taken when start is high and busy is low; each item gives
// exactly one result, shown for one cycle with o_done high, and the result
// cannot be held off. Free, reinit, rejected and exhausted items finish in
// the back stage's idle state; an alloc that pops the free list goes
// through the pop, one read of the link memory, and index times block
// size, and a fresh-block alloc skips the link read. A two-entry queue
// decouples intake from the back stage, so busy only rises when the queue
// is full and the front stage already holds an item. Configuration must be
// written only while no item is in flight, a rule for the user that the block
// does not enforce; it takes effect at once.
`default_nettype none
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS    = 1024,
    parameter int LINK_BYTES    = 8,
    parameter int RESERVE_BYTES = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire t_in_item          i_item,
    output      logic              busy,
    output      logic              o_done,
    output      t_result           o_result,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);
    logic [10:0]        r_block_count;
    logic [12:0]        r_payload_bytes;
    logic [BSIZE_W-1:0] bsize_raw;
    logic [BSIZE_W-1:0] bsize;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    t_cmd               front_cmd;
    t_cmd               q_cmd;

    // round payload plus overhead up to a multiple of 8
    assign bsize_raw = BSIZE_W'(r_payload_bytes) + BSIZE_W'(LINK_BYTES + RESERVE_BYTES + 7);
    assign bsize     = {bsize_raw[BSIZE_W-1:3], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count   <= 11'd1024;
            r_payload_bytes <= 13'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_COUNT:   r_block_count   <= i_cfg_data[10:0];
                CFG_PAYLOAD_BYTES: r_payload_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fbpa_front #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_item        (i_item),
        .i_block_count (r_block_count),
        .i_bsize       (bsize),
        .i_q_full      (q_full),
        .o_busy        (busy),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    fbpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    fbpa_back #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .LINK_BYTES(LINK_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .i_block_count (r_block_count),
        .i_bsize       (bsize),
        .o_pop         (pop),
        .o_done        (o_done),
        .o_result      (o_result)
    );
endmodule
`default_nettype wire

// ===== bench/fixed_block_pool_allocator_core_tb.sv =====
// Self-checking bench for fixed_block_pool_allocator_core: directed corners, then random
// alloc/free/reinit traffic over several pool settings, checked against a free-list tracker.
// Depends on fbpa_pkg and the allocator RTL only.
`default_nettype none
module fixed_block_pool_allocator_core_tb
    import fbpa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_BLOCKS    = 1024;
    localparam int          LINK_BYTES    = 8;
    localparam int          RESERVE_BYTES = 48;
    localparam int          NULL_LINK     = MAX_BLOCKS;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SUB_ITEMS     = 217;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;

    // Tracks the free list and configuration; holds the grants still owed by the block.
    class alloc_tracker;
        logic [10:0] link_mem [MAX_BLOCKS];
        logic [10:0] head;
        logic [10:0] fresh;
        logic [10:0] count_reg;
        logic [12:0] payload_reg;
        t_result     grants_due [$];
        int unsigned live [$];
        int          errors;

        function void clear();
            head        = 11'(NULL_LINK);
            fresh       = '0;
            count_reg   = 11'd1024;
            payload_reg = 13'd64;
            grants_due.delete();
            live.delete();
            errors      = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_BLOCK_COUNT) begin
                count_reg = data[10:0];
            end else begin
                payload_reg = data;
            end
        endfunction

        function int unsigned pool_size();
            return (count_reg < MAX_BLOCKS) ? count_reg : MAX_BLOCKS;
        endfunction

        function int unsigned block_bytes();
            int unsigned raw;
            raw = payload_reg + LINK_BYTES + RESERVE_BYTES;
            return (raw + 7) / 8 * 8;
        endfunction

        function void take_command(t_in_item it);
            t_result     r;
            int unsigned idx;
            r   = '0;
            idx = 0;
            case (it.action)
                ACT_ALLOC: begin
                    if (it.request_bytes + 4 > block_bytes()) begin
                        r.status = STAT_TOO_BIG;
                    end else if (head < NULL_LINK) begin
                        idx  = head;
                        head = link_mem[idx];
                        if (head > NULL_LINK) begin
                            head = 11'(NULL_LINK);
                        end
                        r.granted = 1'b1;
                    end else if (fresh < pool_size()) begin
                        idx   = fresh;
                        fresh = fresh + 1'b1;
                        r.granted = 1'b1;
                    end else begin
                        r.status = STAT_EXHAUST;
                    end
                    if (r.granted) begin
                        r.block_index = idx[9:0];
                        r.byte_offset = OFFS_W'(64'(idx) * block_bytes() + LINK_BYTES);
                        live.push_back(idx);
                    end
                end
                ACT_FREE: begin
                    if (it.free_index >= pool_size()) begin
                        r.status = STAT_BAD_FREE;
                    end else begin
                        link_mem[it.free_index] = head;
                        head      = 11'(it.free_index);
                        r.granted = 1'b1;
                    end
                end
                ACT_REINIT: begin
                    head      = 11'(NULL_LINK);
                    fresh     = '0;
                    r.granted = 1'b1;
                    live.delete();
                end
                default: ;
            endcase
            grants_due.push_back(r);
        endfunction

        function void match_grant(t_result got);
            t_result want;
            if (grants_due.size() == 0) begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted) begin
                $error("granted: expected %0d, actual %0d", want.granted, got.granted);
                errors++;
            end
            if (got.block_index !== want.block_index) begin
                $error("block_index: expected %0d, actual %0d",
                       want.block_index, got.block_index);
                errors++;
            end
            if (got.byte_offset !== want.byte_offset) begin
                $error("byte_offset: expected %0d, actual %0d",
                       want.byte_offset, got.byte_offset);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    t_in_item          i_item;
    logic              busy;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    alloc_tracker      trk;
    int unsigned       send_gap_pct;
    int unsigned       cycles = 0;

    fixed_block_pool_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            trk.match_grant(o_result);
        end
    end

    function automatic t_in_item cmd(logic [1:0] act, int unsigned req, int unsigned fi);
        t_in_item it;
        it.action        = act;
        it.request_bytes = req[15:0];
        it.free_index    = fi[9:0];
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        trk.take_command(it);
    endtask

    // Drop start and hold until every owed grant has come back.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (trk.grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_pool(int unsigned count, int unsigned payload);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_BLOCK_COUNT;
        i_cfg_data = count[CFG_DW-1:0];
        @(negedge i_clk);
        i_cfg_idx  = CFG_PAYLOAD_BYTES;
        i_cfg_data = payload[CFG_DW-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        trk.write_reg(CFG_BLOCK_COUNT, count[CFG_DW-1:0]);
        trk.write_reg(CFG_PAYLOAD_BYTES, payload[CFG_DW-1:0]);
    endtask

    task automatic random_pool();
        int unsigned count;
        int unsigned payload;
        case ($urandom_range(7))
            0:       count = 1;
            1:       count = 2;
            2:       count = MAX_BLOCKS;
            3:       count = $urandom_range(2047, MAX_BLOCKS + 1);
            4:       count = $urandom_range(1023, 65);
            default: count = $urandom_range(64, 3);
        endcase
        if ($urandom_range(31) == 0) begin
            count = 0;
        end
        case ($urandom_range(5))
            0:       payload = 0;
            1:       payload = 4096;
            2:       payload = $urandom_range(8191, 4097);
            default: payload = $urandom_range(4096);
        endcase
        set_pool(count, payload);
    endtask

    // Mostly alloc and free of live blocks; the rest is stray frees, reinits and junk.
    function automatic t_in_item random_cmd();
        int unsigned pick;
        int unsigned limit;
        int unsigned pos;
        int unsigned fi;
        pick  = $urandom_range(99);
        limit = trk.block_bytes() - 4;
        if (pick < 45) begin
            case ($urandom_range(3))
                0:       return cmd(ACT_ALLOC, limit + $urandom_range(1), 0);
                1:       return cmd(ACT_ALLOC, $urandom_range(65535), $urandom_range(1023));
                default: return cmd(ACT_ALLOC, $urandom_range(limit), $urandom_range(1023));
            endcase
        end else if (pick < 80 && trk.live.size() > 0) begin
            pos = $urandom_range(trk.live.size() - 1);
            fi  = trk.live[pos];
            // keep it listed now and then to get a double free later
            if ($urandom_range(19) != 0) begin
                trk.live.delete(pos);
            end
            return cmd(ACT_FREE, $urandom_range(65535), fi);
        end else if (pick < 90) begin
            return cmd(ACT_FREE, $urandom_range(65535), $urandom_range(1023));
        end else if (pick < 93) begin
            return cmd(ACT_REINIT, $urandom_range(65535), $urandom_range(1023));
        end else if (pick < 95) begin
            return cmd(ACT_UNUSED, $urandom_range(65535), $urandom_range(1023));
        end
        return cmd(ACT_ALLOC, $urandom_range(16), 0);
    endfunction

    initial begin
        int unsigned gaps [3];
        int unsigned sent;
        t_in_item    it;

        gaps       = '{7, 45, 0};
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BLOCK_COUNT;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        send_gap_pct = 0;
        trk = new();
        trk.clear();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset pool: 1024 blocks of 120 bytes
        send_item(cmd(ACT_ALLOC, 0, 0));
        send_item(cmd(ACT_ALLOC, 116, 0));
        send_item(cmd(ACT_ALLOC, 117, 0));
        send_item(cmd(ACT_ALLOC, 65535, 1023));
        send_item(cmd(ACT_FREE, 0, 1023));
        send_item(cmd(ACT_ALLOC, 0, 0));
        send_item(cmd(ACT_FREE, 0, 1));
        send_item(cmd(ACT_FREE, 0, 1));
        send_item(cmd(ACT_ALLOC, 8, 0));
        send_item(cmd(ACT_ALLOC, 8, 0));
        send_item(cmd(ACT_UNUSED, 65535, 1023));
        send_item(cmd(ACT_REINIT, 0, 0));
        send_item(cmd(ACT_ALLOC, 0, 0));
        drain();

        // two blocks, no payload
        set_pool(2, 0);
        send_item(cmd(ACT_ALLOC, 52, 0));
        send_item(cmd(ACT_ALLOC, 53, 0));
        send_item(cmd(ACT_ALLOC, 0, 0));
        send_item(cmd(ACT_FREE, 0, 2));
        send_item(cmd(ACT_FREE, 0, 0));
        drain();

        // empty pool: the pushed block still pops, then nothing is left
        set_pool(0, 64);
        send_item(cmd(ACT_ALLOC, 0, 0));
        send_item(cmd(ACT_ALLOC, 0, 0));
        send_item(cmd(ACT_FREE, 0, 0));
        drain();

        // oversized count and payload: offset of the top block wraps
        set_pool(2047, 8191);
        send_item(cmd(ACT_REINIT, 0, 0));
        send_item(cmd(ACT_FREE, 0, 1023));
        send_item(cmd(ACT_ALLOC, 8244, 0));
        send_item(cmd(ACT_ALLOC, 8245, 0));
        drain();

        set_pool(1, 4096);
        send_item(cmd(ACT_ALLOC, 4148, 0));
        send_item(cmd(ACT_ALLOC, 0, 0));
        drain();

        foreach (gaps[m]) begin
            send_gap_pct = gaps[m];
            repeat (3) begin
                random_pool();
                sent = 0;
                while (sent < SUB_ITEMS) begin
                    it = random_cmd();
                    send_item(it);
                    sent++;
                end
                drain();
            end
        end

        repeat (10) @(posedge i_clk);
        if (trk.errors == 0 && trk.grants_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
